// ===== design/packet_retransmit_slot_table_unit_macros.svh =====
`ifndef PACKET_RETRANSMIT_SLOT_TABLE_UNIT_MACROS_SVH
`define PACKET_RETRANSMIT_SLOT_TABLE_UNIT_MACROS_SVH

// a holds -> c in the same cycle
`define PRST_ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("prst check failed");

// a holds -> c in the next cycle
`define PRST_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("prst check failed");

// checked through reset as well
`define PRST_ASSERT_NEXT_NR(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("prst check failed");

`endif

// ===== design/prst_pkg.sv =====
package prst_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned MAX_RESULTS   = 16;
  localparam logic [31:0] INTERVAL_RST  = 32'd6553;
  localparam logic [3:0]  LIMIT_RST     = 4'd10;
  localparam logic [4:0]  COUNT_SAT     = 5'd31;

  typedef enum logic [1:0] {
    KIND_QUEUE  = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_INTERVAL = 1'b0,
    CFG_LIMIT    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  channel;
    logic [15:0] packet_id;
    logic [15:0] buffer_handle;
    logic        needs_retry;
    logic [3:0]  start_count;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  channel_out;
    logic [15:0] packet_id_out;
    logic [15:0] handle_out;
    logic [31:0] send_time;
    logic [4:0]  count_out;
    logic        slot_freed;
    logic        pending;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        retry;
    logic [7:0]  channel;
    logic [15:0] packet_id;
    logic [15:0] handle;
    logic [31:0] due;
    logic [4:0]  count;
  } entry_t;

  typedef struct packed {
    logic [31:0] interval;
    logic [3:0]  limit;
  } cfg_t;

endpackage

// ===== design/prst_mem.sv =====
module prst_mem import prst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/prst_engine.sv =====
module prst_engine import prst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned OCC_W = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_wr_addr,
  output entry_t           mem_wr_data,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  entry_t           mem_rd_data
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  in_item_t          req_r, req_nxt;
  logic              dup_r, dup_nxt;
  logic              found_r, found_nxt;
  logic              hold_v_r, hold_v_nxt;
  out_item_t         hold_r, hold_nxt;
  logic [4:0]        nres_r, nres_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic              hit, is_last, out_free, due, freed, free_found, q_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [31:0]       diff, rearm;
  logic [4:0]        cnt;
  out_item_t         plain;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign mem_rd_addr = idx_r;

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hit      = used_r[idx_r] && mem_rd_data.channel == req_r.channel
               && mem_rd_data.packet_id == req_r.packet_id;
    is_last  = (idx_r == IDX_W'(SLOTS - 1));
    out_free = !out_valid_r || out_ready;
    diff     = req_r.now_time - mem_rd_data.due;
    due      = used_r[idx_r] && (mem_rd_data.due == '0 || !diff[31]);
    rearm    = req_r.now_time + cfg.interval;
    if (rearm == '0) rearm = '1;
    cnt      = (mem_rd_data.count < COUNT_SAT) ? mem_rd_data.count + 5'd1 : COUNT_SAT;
    freed    = !mem_rd_data.retry || cnt > {1'b0, cfg.limit};
    q_ok     = !dup_r && free_found;
    plain    = '0;
    plain.pending = (occ_r != '0);
    plain.last    = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    dup_nxt       = dup_r;
    found_nxt     = found_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    nres_nxt      = nres_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    used_nxt      = used_r;
    occ_nxt       = occ_r;
    mem_we        = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = mem_rd_data;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          idx_nxt    = '0;
          dup_nxt    = 1'b0;
          found_nxt  = 1'b0;
          hold_v_nxt = 1'b0;
          nres_nxt   = '0;
          state_nxt  = (kind_t'(in_data.kind) == KIND_NONE) ? S_FIN : S_RD;
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        unique case (kind_t'(req_r.kind))
          KIND_QUEUE: begin
            if (hit) dup_nxt = 1'b1;
            if (is_last) state_nxt = S_FIN;
            else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          KIND_REMOVE: begin
            if (hit) begin
              used_nxt[idx_r] = 1'b0;
              occ_nxt         = occ_r - 1'b1;
              found_nxt       = 1'b1;
              state_nxt       = S_FIN;
            end else if (is_last) state_nxt = S_FIN;
            else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          KIND_FLUSH: begin
            if (due) begin
              // an older held item must leave before this one takes its place
              if (!hold_v_r || out_free) begin
                if (hold_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = hold_r;
                end
                mem_we                   = 1'b1;
                mem_wr_data.due          = rearm;
                mem_wr_data.count        = cnt;
                hold_nxt.ok              = 1'b1;
                hold_nxt.channel_out     = mem_rd_data.channel;
                hold_nxt.packet_id_out   = mem_rd_data.packet_id;
                hold_nxt.handle_out      = mem_rd_data.handle;
                hold_nxt.send_time       = req_r.now_time;
                hold_nxt.count_out       = cnt;
                hold_nxt.slot_freed      = freed;
                hold_nxt.last            = 1'b0;
                if (freed) begin
                  used_nxt[idx_r] = 1'b0;
                  occ_nxt         = occ_r - 1'b1;
                end
                hold_nxt.pending = (occ_nxt != '0);
                hold_v_nxt       = 1'b1;
                nres_nxt         = nres_r + 5'd1;
                if (is_last || nres_nxt == 5'(MAX_RESULTS)) state_nxt = S_FIN;
                else begin
                  idx_nxt   = idx_r + 1'b1;
                  state_nxt = S_RD;
                end
              end
            end else if (is_last) state_nxt = S_FIN;
            else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (kind_t'(req_r.kind))
            KIND_QUEUE: begin
              out_nxt    = plain;
              out_nxt.ok = q_ok;
              if (q_ok) begin
                mem_we                = 1'b1;
                mem_wr_addr           = free_idx;
                mem_wr_data.retry     = req_r.needs_retry;
                mem_wr_data.channel   = req_r.channel;
                mem_wr_data.packet_id = req_r.packet_id;
                mem_wr_data.handle    = req_r.buffer_handle;
                mem_wr_data.due       = '0;
                mem_wr_data.count     = {1'b0, req_r.start_count};
                used_nxt[free_idx]    = 1'b1;
                occ_nxt               = occ_r + 1'b1;
                out_nxt.pending       = 1'b1;
              end
            end
            KIND_FLUSH: begin
              if (hold_v_r) begin
                out_nxt      = hold_r;
                out_nxt.last = 1'b1;
              end else out_nxt = plain;
            end
            KIND_REMOVE: begin
              out_nxt    = plain;
              out_nxt.ok = found_r;
            end
            default: out_nxt = plain;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      occ_r       <= '0;
      hold_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      occ_r       <= occ_nxt;
      hold_v_r    <= hold_v_nxt;
    end
    idx_r   <= idx_nxt;
    req_r   <= req_nxt;
    dup_r   <= dup_nxt;
    found_r <= found_nxt;
    hold_r  <= hold_nxt;
    nres_r  <= nres_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== design/packet_retransmit_slot_table_unit.sv =====
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/ready    | in_item_t  (kind, channel, id, handle, ...)
// out_    | output    | out_valid/ready   | out_item_t (ok, packet fields, pending, last)
// cfg_    | input     | cfg_we            | cfg_addr selects interval or limit
// An item is taken only when idle, one at a time. Queue and remove read the slot
// memory one slot at a time (read, then evaluate) and take no new item until the
// scan is done; flush likewise, one result per due slot, up to MAX_RESULTS per item.
// Kind three skips the scan. The results wait in the output register; a stalled
// output holds a flush scan and the final result. Reset (synchronous, active low)
// clears the used bits and the fill count.
module packet_retransmit_slot_table_unit import prst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_addr,
  input  logic [31:0] cfg_wdata
);

  cfg_t             cfg_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
  entry_t           mem_wr_data, mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval <= INTERVAL_RST;
      cfg_r.limit    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_INTERVAL: cfg_r.interval <= cfg_wdata;
        CFG_LIMIT:    cfg_r.limit    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  prst_engine #(.SLOTS(SLOTS)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  prst_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== design/prst_checker.sv =====
`include "packet_retransmit_slot_table_unit_macros.svh"

module prst_checker import prst_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `PRST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PRST_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `PRST_ASSERT_NEXT_NR(a_rst_quiet, clk, !rst_n, !out_valid && in_ready)
  `PRST_ASSERT_SAME(a_freed_sent, clk, rst_n, out_valid && out_data.slot_freed, out_data.ok)

endmodule

bind packet_retransmit_slot_table_unit prst_checker u_prst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
